@@ rtl/arqrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arqrb_pkg: shared types and constants of the ARQ receive reorder buffer
// Window size, field widths and the action codes of the result items.
// ----------------------------------------------------------------------------
package arqrb_pkg;

  // Reorder window; slots are taken from the low sequence bits (power of two)
  localparam int unsigned WINDOW      = 16;
  localparam int unsigned SLOT_W      = $clog2(WINDOW);
  localparam int unsigned MAX_PAYLOAD = 1024;

  // Field widths
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned ACT_W = 2;

  // Sequence number expected after reset
  localparam logic [SEQ_W-1:0] RESET_EXPECTED_SEQ = SEQ_W'(1);

  // Action of one result item
  typedef enum logic [ACT_W-1:0] {
    ACT_DISCARD = 2'd0,
    ACT_STORE   = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_DROP    = 2'd3
  } action_e;

endpackage : arqrb_pkg
`default_nettype wire

@@ rtl/arq_receive_reorder_buffer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arq_receive_reorder_buffer_top: selective-repeat ARQ receive window
// Classifies arriving data packets, stores in-window ones and releases them
// in sequence order.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o) carries one packet per item.
// - Output channel (out_valid_o / out_stall_i) carries the result items;
//   last_o marks the final item caused by one packet.
// - cfg_we_i / cfg_wdata_i load the expected sequence number and empty the
//   window; write only while the block is idle.
// - A packet is accepted in ST_IDLE and classified in ST_EVAL, when its
//   first result enters the output register. Each in-order delivery adds a
//   ST_DELIVER step; the length of the next slot is prefetched from the
//   slot length memory, whose read is registered.
// - A stalled output holds its item; classification and delivery wait for
//   the output register to free up, and no new packet is taken meanwhile.
// - Reset sets the expected sequence number to 1 and clears all present
//   bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arq_receive_reorder_buffer_top
  import arqrb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration
  input  wire logic              cfg_we_i,
  input  wire logic [SEQ_W-1:0]  cfg_wdata_i,
  // Packet input
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [SEQ_W-1:0]  packet_seq_i,
  input  wire logic [LEN_W-1:0]  payload_length_i,
  input  wire logic              checksum_ok_i,
  // Result output
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ACT_W-1:0]       action_o,
  output logic [SEQ_W-1:0]       result_seq_o,
  output logic [SLOT_W-1:0]      buffer_slot_o,
  output logic [LEN_W-1:0]       result_length_o,
  output logic                   last_o
);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_EVAL    = 2'd1;
  localparam logic [1:0] ST_DELIVER = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SEQ_W-1:0]  exp_q, exp_d;
  logic [WINDOW-1:0] present_q, present_d;

  // Captured packet
  logic [SEQ_W-1:0]  seq_q;
  logic [LEN_W-1:0]  len_q;
  logic              ok_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  action_e           act_q, act_d;
  logic [SEQ_W-1:0]  rseq_q, rseq_d;
  logic [LEN_W-1:0]  rlen_q, rlen_d;
  logic              last_q, last_d;

  // Slot length memory and its forwarding path
  logic [LEN_W-1:0]  len_mem [WINDOW];
  logic [LEN_W-1:0]  ram_q;
  logic              fwd_q;
  logic [LEN_W-1:0]  fwd_len_q;
  logic              mem_we;
  logic [SLOT_W-1:0] rd_addr;
  logic [LEN_W-1:0]  rd_len;

  logic              in_accept;
  logic              out_load;
  logic [SEQ_W-1:0]  seq_dist;
  logic [SLOT_W-1:0] seq_slot;
  logic [SLOT_W-1:0] exp_slot;
  logic [SLOT_W-1:0] exp_next_slot;
  logic [SEQ_W-1:0]  exp_inc;

  assign in_accept     = in_valid_i && !in_stall_o;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_load      = !out_valid_q || !out_stall_i;
  assign seq_dist      = seq_q - exp_q;
  assign seq_slot      = seq_q[SLOT_W-1:0];
  assign exp_slot      = exp_q[SLOT_W-1:0];
  assign exp_inc       = exp_q + SEQ_W'(1);
  assign exp_next_slot = exp_inc[SLOT_W-1:0];
  assign rd_addr       = exp_d[SLOT_W-1:0];
  assign rd_len        = fwd_q ? fwd_len_q : ram_q;

  // Classification, storing and in-order release
  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    present_d   = present_q;
    out_valid_d = out_valid_q && out_stall_i;
    act_d       = act_q;
    rseq_d      = rseq_q;
    rlen_d      = rlen_q;
    last_d      = last_q;
    mem_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          rseq_d      = seq_q;
          rlen_d      = '0;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
          if (!ok_q || (len_q > LEN_W'(MAX_PAYLOAD))) begin
            act_d = ACT_DROP;
          end else if (seq_dist[SEQ_W-1]) begin
            // behind the window: already delivered
            act_d = ACT_DISCARD;
          end else if (seq_dist >= SEQ_W'(WINDOW)) begin
            act_d = ACT_DROP;
          end else if (present_q[seq_slot]) begin
            act_d = ACT_DISCARD;
          end else begin
            act_d               = ACT_STORE;
            rlen_d              = len_q;
            mem_we              = 1'b1;
            present_d[seq_slot] = 1'b1;
            // release follows if the expected slot is now filled
            if ((seq_dist == '0) || present_q[exp_slot]) begin
              last_d  = 1'b0;
              state_d = ST_DELIVER;
            end
          end
        end
      end
      ST_DELIVER: begin
        if (out_load) begin
          out_valid_d         = 1'b1;
          act_d               = ACT_DELIVER;
          rseq_d              = exp_q;
          rlen_d              = rd_len;
          last_d              = !present_q[exp_next_slot];
          present_d[exp_slot] = 1'b0;
          exp_d               = exp_inc;
          if (!present_q[exp_next_slot]) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // New connection: load expected sequence and empty the window
    if (cfg_we_i) begin
      exp_d     = cfg_wdata_i;
      present_d = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_q       <= RESET_EXPECTED_SEQ;
      present_q   <= '0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= mem_we && (seq_slot == rd_addr);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      seq_q <= packet_seq_i;
      len_q <= payload_length_i;
      ok_q  <= checksum_ok_i;
    end
    act_q     <= act_d;
    rseq_q    <= rseq_d;
    rlen_q    <= rlen_d;
    last_q    <= last_d;
    fwd_len_q <= len_q;
  end

  // Slot length memory: one write port, registered read of the next slot
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      len_mem[seq_slot] <= len_q;
    end
    ram_q <= len_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = act_q;
  assign result_seq_o    = rseq_q;
  assign buffer_slot_o   = rseq_q[SLOT_W-1:0];
  assign result_length_o = rlen_q;
  assign last_o          = last_q;

endmodule : arq_receive_reorder_buffer_top
`default_nettype wire

@@ verif/arq_receive_reorder_buffer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_receive_reorder_buffer_top_tb: self-checking bench of the ARQ receiver
// Sends data packets through the valid/stall input while both channels
// idle in random bursts. A window model in the bench predicts the action,
// sequence, slot and length of every result item, and each accepted result
// is compared in order with those predictions. Runs cover several starting
// sequence numbers, 2^32 wraparound and a long output hold-off.
// ----------------------------------------------------------------------------
module arq_receive_reorder_buffer_top_tb;
  import arqrb_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One predicted result item
  typedef struct {
    action_e           action;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              last;
  } arq_result_t;

  // Receive window model: tracks expected sequence and slots, queues results
  class arq_window_model;
    logic [SEQ_W-1:0] expected_seq;
    bit               present [WINDOW];
    logic [LEN_W-1:0] slot_len [WINDOW];
    arq_result_t      awaited[$];
    int unsigned      errors;

    function new();
      errors = 0;
      load_initial(RESET_EXPECTED_SEQ);
    endfunction

    // Register write: new connection, empty window
    function void load_initial(logic [SEQ_W-1:0] value);
      expected_seq = value;
      foreach (present[i]) present[i] = 1'b0;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function void add_result(action_e act, logic [SEQ_W-1:0] seq,
                             logic [LEN_W-1:0] len, logic last);
      arq_result_t r;
      r.action = act;
      r.seq    = seq;
      r.slot   = SLOT_W'(seq % WINDOW);
      r.len    = len;
      r.last   = last;
      awaited.push_back(r);
    endfunction

    // Classify an accepted packet and queue the results it causes
    function void accept_packet(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len, logic ok);
      logic [SEQ_W-1:0] seq_dist;
      int unsigned      slot;
      int unsigned      count;
      seq_dist = seq - expected_seq;
      slot = seq % WINDOW;
      if (!ok || len > MAX_PAYLOAD) begin
        add_result(ACT_DROP, seq, '0, 1'b1);
      end else if (seq_dist[SEQ_W-1]) begin
        // behind the window: delivered long ago
        add_result(ACT_DISCARD, seq, '0, 1'b1);
      end else if (seq_dist >= WINDOW) begin
        add_result(ACT_DROP, seq, '0, 1'b1);
      end else if (present[slot]) begin
        add_result(ACT_DISCARD, seq, '0, 1'b1);
      end else begin
        present[slot]  = 1'b1;
        slot_len[slot] = len;
        add_result(ACT_STORE, seq, len, 1'b0);
        count = 1;
        // release in order while the expected slot is filled
        while (present[expected_seq % WINDOW] && count < WINDOW + 1) begin
          add_result(ACT_DELIVER, expected_seq, slot_len[expected_seq % WINDOW], 1'b0);
          present[expected_seq % WINDOW] = 1'b0;
          expected_seq = expected_seq + 1'b1;
          count++;
        end
        awaited[awaited.size()-1].last = 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [SEQ_W-1:0] exp_val,
                                logic [SEQ_W-1:0] got_val);
      if (got_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, name, exp_val, got_val);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest prediction
    function void check_result(logic [ACT_W-1:0] act, logic [SEQ_W-1:0] seq,
                               logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] len,
                               logic last);
      arq_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %0h %0h %0h %0h %0h",
                 $time, act, seq, slot, len, last);
        errors++;
        return;
      end
      r = awaited.pop_front();
      compare_field("action", SEQ_W'(r.action), SEQ_W'(act));
      compare_field("result_seq", r.seq, seq);
      compare_field("buffer_slot", SEQ_W'(r.slot), SEQ_W'(slot));
      compare_field("result_length", SEQ_W'(r.len), SEQ_W'(len));
      compare_field("last", SEQ_W'(r.last), SEQ_W'(last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [SEQ_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SEQ_W-1:0]  packet_seq = '0;
  logic [LEN_W-1:0]  payload_length = '0;
  logic              checksum_ok = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ACT_W-1:0]  action;
  logic [SEQ_W-1:0]  result_seq;
  logic [SLOT_W-1:0] buffer_slot;
  logic [LEN_W-1:0]  result_length;
  logic              result_last;

  int unsigned       out_stall_pct = 0;
  int unsigned       in_gap_pct = 0;
  bit                hold_request = 1'b0;
  arq_window_model   window_model = new();

  arq_receive_reorder_buffer_top DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .packet_seq_i     (packet_seq),
    .payload_length_i (payload_length),
    .checksum_ok_i    (checksum_ok),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .action_o         (action),
    .result_seq_o     (result_seq),
    .buffer_slot_o    (buffer_slot),
    .result_length_o  (result_length),
    .last_o           (result_last)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Packets accepted by the block feed the model
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) begin
      window_model.accept_packet(packet_seq, payload_length, checksum_ok);
    end
  end

  // Results accepted from the block are checked
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      window_model.check_result(action, result_seq, buffer_slot, result_length, result_last);
    end
  end

  // Receiver stall: random bursts, or one long hold-off on request
  initial begin : receiver_stall
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(99, 0) < out_stall_pct) begin
        burst = $urandom_range(17, 1);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one packet, with an optional idle burst first
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                             input logic ok);
    int unsigned gap;
    if ($urandom_range(99, 0) < in_gap_pct) begin
      gap = $urandom_range(17, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    packet_seq     <= seq;
    payload_length <= len;
    checksum_ok    <= ok;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_drained();
    while (window_model.outstanding() != 0) @(posedge clk);
  endtask

  // Load the starting sequence number with the block idle
  task automatic load_initial_seq(input logic [SEQ_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_model.load_initial(value);
  endtask

  // Mostly in-window traffic around the expected sequence, plus noise
  task automatic send_random_packets(input int unsigned count, input bit with_hold);
    int unsigned      kind;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic             ok;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(99, 0);
      base = window_model.expected_seq;
      seq  = base + $urandom_range(WINDOW - 1, 0);
      len  = LEN_W'($urandom_range(MAX_PAYLOAD, 0));
      ok   = 1'b1;
      if (kind < 20) begin
        seq = base;
      end else if (kind < 70) begin
        // in window, random offset
      end else if (kind < 76) begin
        seq = base - $urandom_range(40, 1);
      end else if (kind < 82) begin
        seq = base + $urandom_range(200, WINDOW);
      end else if (kind < 88) begin
        seq = $urandom();
      end else if (kind < 94) begin
        ok  = 1'b0;
        len = LEN_W'($urandom_range(2047, 0));
      end else begin
        len = LEN_W'($urandom_range(2047, MAX_PAYLOAD + 1));
      end
      if (with_hold && i == count / 3) hold_request = 1'b1;
      send_packet(seq, len, ok);
    end
  endtask

  // Main sequence
  initial begin : stimulus
    logic [SEQ_W-1:0] start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of the expected sequence (1): classification corners
    out_stall_pct = 15;
    in_gap_pct    = 15;
    send_packet(32'd1, 11'd5, 1'b0);                  // checksum failed
    send_packet(32'd1, 11'd1025, 1'b1);               // just above max payload
    send_packet(32'd1, 11'd2047, 1'b1);               // all length bits set
    send_packet(32'd0, 11'd10, 1'b1);                 // just behind
    send_packet(32'h8000_0001, 11'd10, 1'b1);         // half the space ahead: behind
    send_packet(32'h8000_0000, 11'd10, 1'b1);         // far ahead: beyond
    send_packet(32'd17, 11'd10, 1'b1);                // one past the window
    send_packet(32'd16, 11'd1024, 1'b1);              // last window slot
    send_packet(32'd16, 11'd3, 1'b1);                 // duplicate of a buffered one
    send_packet(32'd3, 11'd0, 1'b1);
    send_packet(32'd2, 11'd7, 1'b1);
    send_packet(32'd1, 11'd1, 1'b1);                  // releases 1, 2, 3
    send_random_packets(80, 1'b0);

    // Window across the 2^32 wrap: fill it, then release all 16 at once
    load_initial_seq(32'hFFFF_FFF8);
    out_stall_pct = 30;
    in_gap_pct    = 10;
    start = window_model.expected_seq;
    for (int unsigned k = 1; k < WINDOW; k++) send_packet(start + k, LEN_W'(k * 60), 1'b1);
    send_packet(start, 11'd1024, 1'b1);
    send_random_packets(80, 1'b1);

    load_initial_seq(32'h0000_0000);
    out_stall_pct = 10;
    in_gap_pct    = 30;
    send_random_packets(60, 1'b0);

    load_initial_seq(32'hFFFF_FFFF);
    out_stall_pct = 20;
    in_gap_pct    = 20;
    send_random_packets(60, 1'b0);

    // Random start, no idling on either side
    load_initial_seq($urandom());
    out_stall_pct = 0;
    in_gap_pct    = 0;
    send_random_packets(70, 1'b0);

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (window_model.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/arqrb_pkg.sv
rtl/arq_receive_reorder_buffer_top.sv
verif/arq_receive_reorder_buffer_top_tb.sv
